### design/fscp_pkg.sv
// shared constants and types for the framed servo command parser
// no dependencies; imported by every module of the block except fscp_ram
`default_nettype none

package fscp_pkg;

   localparam int BUF_CHARS = 32;
   localparam int IDX_W     = $clog2(BUF_CHARS);
   localparam int NUM_BANKS = 2;
   localparam int MEM_DEPTH = NUM_BANKS * BUF_CHARS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef logic [IDX_W-1:0] idx_type;

   // one finished frame handed from front to back
   typedef struct packed {
      logic valid;
      logic bank;
   } fscp_job_type;

   // back is done with a frame bank
   typedef struct packed {
      logic valid;
      logic bank;
   } fscp_release_type;

endpackage

`default_nettype wire

### design/fscp_ram.sv
// generic single write port, single read port ram with registered read data
// standalone; no package dependency
`default_nettype none

module fscp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### design/fscp_front.sv
// front end: frame detection, character storage into a ping-pong buffer
// depends on fscp_pkg; feeds fscp_queue and the character ram
`default_nettype none

module fscp_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_rx_byte,
   output logic                           wr_en,
   output logic [fscp_pkg::ADDR_W-1:0]    wr_addr,
   output logic [7:0]                     wr_data,
   output fscp_pkg::fscp_job_type         push,
   input  wire fscp_pkg::fscp_release_type release_in
);

   import fscp_pkg::*;

   logic                 in_frame_ff, in_frame_in;
   idx_type              widx_ff, widx_in;
   logic                 bank_ff, bank_in;
   logic [NUM_BANKS-1:0] busy_ff, busy_in;
   logic                 accept;
   logic                 is_close;

   assign req_stall = in_frame_ff & busy_ff[bank_ff];
   assign accept    = req_valid & ~req_stall;
   assign is_close  = (req_rx_byte == CH_CLOSE);

   assign wr_en   = accept & in_frame_ff;
   assign wr_addr = {bank_ff, widx_ff};
   assign wr_data = is_close ? CH_NUL : req_rx_byte;

   assign push.valid = accept & in_frame_ff & is_close;
   assign push.bank  = bank_ff;

   always_comb begin
      in_frame_in = in_frame_ff;
      widx_in     = widx_ff;
      bank_in     = bank_ff;
      busy_in     = busy_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            in_frame_in = (req_rx_byte == CH_OPEN);
         end else if (is_close) begin
            in_frame_in       = 1'b0;
            widx_in           = '0;
            bank_in           = ~bank_ff;
            busy_in[bank_ff]  = 1'b1;
         end else if (widx_ff != idx_type'(BUF_CHARS - 1)) begin
            widx_in = widx_ff + idx_type'(1);
         end
      end
      if (release_in.valid) begin
         busy_in[release_in.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         widx_ff     <= '0;
         bank_ff     <= 1'b0;
         busy_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         widx_ff     <= widx_in;
         bank_ff     <= bank_in;
         busy_ff     <= busy_in;
      end
   end

endmodule

`default_nettype wire

### design/fscp_queue.sv
// short queue of finished frame banks between front and back
// depends on fscp_pkg
`default_nettype none

module fscp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fscp_pkg::fscp_job_type push,
   input  wire logic                   pop,
   output fscp_pkg::fscp_job_type      head
);

   import fscp_pkg::*;

   logic               ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] rd_ptr_ff, wr_ptr_ff;
   logic [Q_PTR_W:0]   count_ff;

   assign head.valid = (count_ff != '0);
   assign head.bank  = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         ent_ff[wr_ptr_ff] <= push.bank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
         end
         if (push.valid && !pop) begin
            count_ff <= count_ff + (Q_PTR_W + 1)'(1);
         end else if (pop && !push.valid) begin
            count_ff <= count_ff - (Q_PTR_W + 1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

### design/fscp_back.sv
// back end: walks a stored frame one character per cycle and builds the result
// depends on fscp_pkg; reads the character ram, pops fscp_queue
`default_nettype none

module fscp_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fscp_pkg::fscp_job_type  head,
   output logic                         pop,
   output logic [fscp_pkg::ADDR_W-1:0]  rd_addr,
   input  wire logic [7:0]              rd_data,
   output fscp_pkg::fscp_release_type   release_out,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic                         rsp_servo_select,
   output logic signed [15:0]           rsp_angle,
   output logic signed [15:0]           rsp_joint_number,
   output logic                         rsp_status
);

   import fscp_pkg::*;

   localparam logic [19:0] MAG_CLAMP = 20'd40000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_WS,
      S_A_DIG,
      S_A_SEEK,
      S_J_WS,
      S_J_DIG,
      S_J_SEEK,
      S_HOLD
   } state_type;

   function automatic logic signed [15:0] sat16(input logic [15:0] m, input logic n);
      logic signed [15:0] r;
      if (n) begin
         r = (m > 16'd32768) ? 16'sh8000 : signed'(~m + 16'd1);
      end else begin
         r = (m > 16'd32767) ? 16'sh7FFF : signed'(m);
      end
      return r;
   endfunction

   state_type          state_ff, scan_next;
   logic               bank_ff;
   idx_type            rd_idx_ff;
   logic [15:0]        mag_ff;
   logic               neg_ff;
   logic signed [15:0] angle_ff;
   logic [19:0]        prod;
   logic [15:0]        mag_in;
   logic signed [15:0] num_sat;
   logic               is_blank, is_digit, is_sign, in_joint;
   logic               take_digit, take_sign, to_joint, fin_ok, fin_err;

   assign is_blank = (rd_data == CH_SPACE) || (rd_data >= CH_TAB && rd_data <= CH_CR);
   assign is_digit = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
   assign is_sign  = (rd_data == CH_PLUS) || (rd_data == CH_MINUS);
   assign in_joint = state_ff inside {S_J_WS, S_J_DIG, S_J_SEEK};

   assign prod   = 20'({mag_ff, 3'b000}) + 20'({mag_ff, 1'b0}) + 20'(rd_data[3:0]);
   assign mag_in = (prod > MAG_CLAMP) ? MAG_CLAMP[15:0] : prod[15:0];
   assign num_sat = sat16(mag_ff, neg_ff);

   assign pop     = (state_ff == S_IDLE) && head.valid;
   assign rd_addr = (state_ff == S_IDLE) ? {head.bank, idx_type'(0)} : {bank_ff, rd_idx_ff};

   assign release_out.valid = fin_ok | fin_err;
   assign release_out.bank  = bank_ff;

   always_comb begin
      scan_next  = state_ff;
      take_digit = 1'b0;
      take_sign  = 1'b0;
      to_joint   = 1'b0;
      fin_ok     = 1'b0;
      fin_err    = 1'b0;
      case (state_ff)
         S_A_WS, S_J_WS, S_A_DIG, S_J_DIG, S_A_SEEK, S_J_SEEK: begin
            if ((state_ff == S_A_WS || state_ff == S_J_WS) && is_blank) begin
               scan_next = state_ff;
            end else if ((state_ff == S_A_WS || state_ff == S_J_WS) && is_sign) begin
               take_sign = 1'b1;
               scan_next = in_joint ? S_J_DIG : S_A_DIG;
            end else if (state_ff != S_A_SEEK && state_ff != S_J_SEEK && is_digit) begin
               take_digit = 1'b1;
               scan_next  = in_joint ? S_J_DIG : S_A_DIG;
            end else if (rd_data == CH_NUL) begin
               fin_err   = 1'b1;
               scan_next = S_HOLD;
            end else if (rd_data == CH_COMMA) begin
               if (in_joint) begin
                  fin_ok    = 1'b1;
                  scan_next = S_HOLD;
               end else begin
                  to_joint  = 1'b1;
                  scan_next = S_J_WS;
               end
            end else begin
               scan_next = in_joint ? S_J_SEEK : S_A_SEEK;
            end
         end
         default: begin
            scan_next = state_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  bank_ff   <= head.bank;
                  rd_idx_ff <= idx_type'(1);
                  mag_ff    <= '0;
                  neg_ff    <= 1'b0;
                  state_ff  <= S_A_WS;
               end
            end
            S_A_WS, S_A_DIG, S_A_SEEK, S_J_WS, S_J_DIG, S_J_SEEK: begin
               rd_idx_ff <= rd_idx_ff + idx_type'(1);
               state_ff  <= scan_next;
               if (take_digit) begin
                  mag_ff <= mag_in;
               end
               if (take_sign) begin
                  neg_ff <= (rd_data == CH_MINUS);
               end
               if (to_joint) begin
                  angle_ff <= num_sat;
                  mag_ff   <= '0;
                  neg_ff   <= 1'b0;
               end
               if (fin_ok) begin
                  rsp_valid        <= 1'b1;
                  rsp_servo_select <= (num_sat != 16'sd2);
                  rsp_angle        <= angle_ff;
                  rsp_joint_number <= num_sat;
                  rsp_status       <= 1'b0;
               end
               if (fin_err) begin
                  rsp_valid        <= 1'b1;
                  rsp_servo_select <= 1'b0;
                  rsp_angle        <= '0;
                  rsp_joint_number <= '0;
                  rsp_status       <= 1'b1;
               end
            end
            S_HOLD: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/framed_servo_command_parser.sv
// Framed servo command parser. The front takes one received byte per cycle while req_stall
// is low; bytes between '<' and '>' are stored in one of two 32-character frame banks. At
// '>' the bank is queued and the back walks it one character per cycle through the single
// ram read port, then holds one result until it is taken. The front keeps taking bytes into
// the other bank meanwhile and stalls only when both banks wait to be parsed. Text is
// "angle,joint,..." with atoi rules and 16-bit saturation; a missing first or second
// comma gives status 1 with zero fields.
// depends on fscp_pkg, fscp_front, fscp_queue, fscp_back, fscp_ram
`default_nettype none

module framed_servo_command_parser (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic               rsp_servo_select,
   output logic signed [15:0] rsp_angle,
   output logic signed [15:0] rsp_joint_number,
   output logic               rsp_status
);

   import fscp_pkg::*;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   fscp_job_type      push, head;
   fscp_release_type  release_sig;
   logic              pop;

   fscp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .push        (push),
      .release_in  (release_sig)
   );

   fscp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   fscp_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fscp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .release_out      (release_sig),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_servo_select (rsp_servo_select),
      .rsp_angle        (rsp_angle),
      .rsp_joint_number (rsp_joint_number),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire
